// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

	// Width of one stored cell: attribute in the high byte, character in the low byte.
	localparam int CELL_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;

	// Command codes carried by the cmd field.
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Character and cell constants.
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE      = 8'h0A;
	localparam logic [CELL_W-1:0] BLANK_CELL        = 16'h0720;
	localparam logic [CHAR_W-1:0] DEFAULT_COLOR_RST = 8'h07;

	// One result as handed from the sequencer to the output register.
	typedef struct packed {
		logic [CELL_W-1:0]    cell_value;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [COL_OUT_W-1:0] cursor_col;
		logic                 did_scroll;
	} tcw_result_t;

endpackage

// ===== rtl/tcw_cell_ram.sv =====
// Cell store: one write port and one registered read port.
`timescale 1ns / 1ps

module tcw_cell_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tcw_seq.sv =====
// Sequencer: cursor, command decode and the sweep that clears or scrolls the store.
`timescale 1ns / 1ps

module tcw_seq #(
	parameter int ROWS   = 25,
	parameter int COLS   = 80,
	parameter int ADDR_W = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        out_free,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  char_code,
	input  logic                        use_item_color,
	input  logic [7:0]                  item_color,
	input  logic [4:0]                  read_row,
	input  logic [6:0]                  read_col,
	input  logic [7:0]                  default_color,
	output logic                        res_load,
	output tcw_pkg::tcw_result_t        res,
	output logic                        ram_we,
	output logic [ADDR_W-1:0]           ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]  ram_wdata,
	output logic [ADDR_W-1:0]           ram_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);
	import tcw_pkg::*;

	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLS);
	localparam int NCELLS = ROWS * COLS;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(NCELLS - COLS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);
	localparam logic [RW-1:0]     LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0]     LAST_COL  = CW'(COLS - 1);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_DRAIN,
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              scroll_q;
	logic              report_q;
	logic              rd_ok_q;
	logic [RW-1:0]     cursor_row_q;
	logic [CW-1:0]     cursor_col_q;
	logic              wr_s1;
	logic              blank_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic              accept;
	logic              is_newline;
	logic              wrap;
	logic              at_bottom;
	logic              scroll_now;
	logic [RW-1:0]     put_row;
	logic [CW-1:0]     put_col;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_in_range;
	logic [7:0]        attr;

	// Requests are taken only when idle and the output register can take the result.
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;

	// Cursor advance for a put request.
	assign is_newline = (char_code == CHAR_NEWLINE);
	assign wrap       = is_newline || (cursor_col_q == LAST_COL);
	assign at_bottom  = (cursor_row_q == LAST_ROW);
	assign scroll_now = wrap && at_bottom;
	assign put_col    = wrap ? '0 : cursor_col_q + 1'b1;
	assign put_row    = (wrap && !at_bottom) ? cursor_row_q + 1'b1 : cursor_row_q;

	// Linear addresses of the cursor cell and of the cell asked for by a read.
	assign cur_addr    = ADDR_W'(cursor_row_q) * ROW_STEP + ADDR_W'(cursor_col_q);
	assign rd_addr     = ADDR_W'(read_row) * ROW_STEP + ADDR_W'(read_col);
	assign rd_in_range = (read_row < ROWS) && (read_col < COLS);
	assign attr        = use_item_color ? item_color : default_color;

	// Write port: the sweep stage has priority; a put writes only while idle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = blank_s1 ? BLANK_CELL : ram_rdata;
		if (wr_s1) begin
			ram_we = 1'b1;
		end else if (accept && (cmd == CMD_PUT) && !is_newline) begin
			ram_we    = 1'b1;
			ram_waddr = cur_addr;
			ram_wdata = {attr, char_code};
		end
	end

	// Read port: the sweep reads one row ahead, otherwise the read request address.
	assign ram_raddr = (state_q == ST_SWEEP) ? ptr_q + ROW_STEP : rd_addr;

	// Result handed to the output register.
	always_comb begin
		res_load       = 1'b0;
		res.cell_value = '0;
		res.cursor_row = ROW_OUT_W'(cursor_row_q);
		res.cursor_col = COL_OUT_W'(cursor_col_q);
		res.did_scroll = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_PUT: begin
							res_load       = !scroll_now;
							res.cursor_row = ROW_OUT_W'(put_row);
							res.cursor_col = COL_OUT_W'(put_col);
						end
						CMD_CLEAR: res_load = 1'b0;
						CMD_READ:  res_load = 1'b0;
						default:   res_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				res_load       = 1'b1;
				res.cell_value = rd_ok_q ? ram_rdata : '0;
			end
			ST_DRAIN: begin
				res_load       = report_q;
				res.did_scroll = scroll_q;
			end
			default: res_load = 1'b0;
		endcase
	end

	// State, cursor and sweep stage. Reset starts with a blanking sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			ptr_q        <= '0;
			scroll_q     <= 1'b0;
			report_q     <= 1'b0;
			rd_ok_q      <= 1'b0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			wr_s1        <= 1'b0;
			blank_s1     <= 1'b0;
			addr_s1      <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					wr_s1    <= 1'b1;
					addr_s1  <= ptr_q;
					blank_s1 <= !(scroll_q && (ptr_q < COPY_END));
					ptr_q    <= ptr_q + 1'b1;
					if (ptr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					wr_s1   <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PUT: begin
								cursor_row_q <= put_row;
								cursor_col_q <= put_col;
								if (scroll_now) begin
									scroll_q <= 1'b1;
									report_q <= 1'b1;
									ptr_q    <= '0;
									state_q  <= ST_SWEEP;
								end
							end
							CMD_CLEAR: begin
								cursor_row_q <= '0;
								cursor_col_q <= '0;
								scroll_q     <= 1'b0;
								report_q     <= 1'b1;
								ptr_q        <= '0;
								state_q      <= ST_SWEEP;
							end
							CMD_READ: begin
								rd_ok_q <= rd_in_range;
								state_q <= ST_READ;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/text_console_char_writer_top.sv =====
// Top level of the text console character writer.
`timescale 1ns / 1ps

// Text console of ROWS by COLS 16-bit cells (attribute high byte, character low
// byte) with a cursor, held in one synchronous cell memory. A put of any character
// but a newline writes one cell in the cycle it is accepted. A read takes its
// result from the registered memory read in the cycle after it is accepted. A
// clear request, or a put that moves the cursor past the bottom row and so
// scrolls the screen, sweeps the memory one cell a cycle through its single write
// port, copying each cell up one row and blanking the bottom row, or blanking
// everything. After reset the same sweep blanks the store, and no request is
// taken until it is done. Every request yields exactly one result. default_color
// is written through cfg_we and cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
module text_console_char_writer_top #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic        use_item_color,
	input  logic [7:0]  item_color,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] cell_value,
	output logic [4:0]  cursor_row_now,
	output logic [6:0]  cursor_col_now,
	output logic        did_scroll
);
	import tcw_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int ADDR_W = $clog2(NCELLS);

	logic [7:0]        default_color_q;
	logic              out_valid_q;
	tcw_result_t       out_res_q;
	logic              out_free;
	logic              res_load;
	tcw_result_t       res;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Default color register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= DEFAULT_COLOR_RST;
		end else if (cfg_we) begin
			default_color_q <= cfg_wdata;
		end
	end

	tcw_seq #(
		.ROWS   (ROWS),
		.COLS   (COLS),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.out_free       (out_free),
		.cmd            (cmd),
		.char_code      (char_code),
		.use_item_color (use_item_color),
		.item_color     (item_color),
		.read_row       (read_row),
		.read_col       (read_col),
		.default_color  (default_color_q),
		.res_load       (res_load),
		.res            (res),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

	tcw_cell_ram #(
		.DEPTH  (NCELLS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: holds one result until the receiver takes it.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_value     = out_res_q.cell_value;
	assign cursor_row_now = out_res_q.cursor_row;
	assign cursor_col_now = out_res_q.cursor_col;
	assign did_scroll     = out_res_q.did_scroll;

	// A new result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded over a pending result");

	// A read request produces its result in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (cmd == CMD_READ)) |=> res_load)
		else $error("read result not produced one cycle after the request");

	// A scroll always leaves the cursor at the start of the bottom row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && did_scroll) |->
			((cursor_col_now == '0) && (cursor_row_now == ROW_OUT_W'(ROWS - 1))))
		else $error("scroll result with cursor off the bottom row start");

	// A result with cell data never reports a scroll; only read results carry cell data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res.cell_value != '0)) |-> !res.did_scroll)
		else $error("cell data on a scrolling result");

endmodule

// ===== dv/tb_text_console_char_writer_top.sv =====
// Self-checking testbench for the text console character writer top level.
`timescale 1ns / 1ps

module tb_text_console_char_writer_top;
	import tcw_pkg::*;

	localparam int ROWS   = 25;
	localparam int COLS   = 80;
	localparam int NCELLS = ROWS * COLS;

	// The cmd field has one code with no function; the block must ignore it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// A scroll or a clear sweeps the whole store once.
	localparam int SWEEP_CYCLES    = NCELLS + 2;
	localparam int PRESSURE_CYCLES = 400;

	// About 1500 requests, each at worst a full sweep plus the longest gap on
	// both sides, stay well within this limit.
	localparam int CYCLE_LIMIT = 20_000_000;

	typedef struct {
		logic [1:0] op;
		logic [7:0] ch;
		logic       own_color;
		logic [7:0] color;
		logic [4:0] row;
		logic [6:0] col;
	} console_req_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [7:0]  cfg_wdata      = 8'h00;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd            = CMD_PUT;
	logic [7:0]  char_code      = 8'h00;
	logic        use_item_color = 1'b0;
	logic [7:0]  item_color     = 8'h00;
	logic [4:0]  read_row       = 5'd0;
	logic [6:0]  read_col       = 7'd0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [15:0] cell_value;
	logic [4:0]  cursor_row_now;
	logic [6:0]  cursor_col_now;
	logic        did_scroll;

	// Mirror of the screen, the cursor and the default attribute.
	logic [15:0] screen_cells [NCELLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  attr_default;
	tcw_result_t pending_results [$];

	int error_count  = 0;
	int cycle_count  = 0;
	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left    = 0;
	int stall_left   = 0;

	text_console_char_writer_top #(
		.ROWS(ROWS),
		.COLS(COLS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.char_code     (char_code),
		.use_item_color(use_item_color),
		.item_color    (item_color),
		.read_row      (read_row),
		.read_col      (read_col),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cell_value    (cell_value),
		.cursor_row_now(cursor_row_now),
		.cursor_col_now(cursor_col_now),
		.did_scroll    (did_scroll)
	);

	always #10 clk = ~clk;

	// Blanks every cell and homes the cursor, as reset and clear do.
	function automatic void blank_screen();
		for (int i = 0; i < NCELLS; i++) screen_cells[i] = BLANK_CELL;
		cur_row = 0;
		cur_col = 0;
	endfunction

	// Applies one request to the mirror and returns the result it should give.
	function automatic tcw_result_t console_apply(console_req_t r);
		tcw_result_t res;
		logic [7:0]  attr;
		res = '0;
		case (r.op)
			CMD_PUT: begin
				attr = r.own_color ? r.color : attr_default;
				// A newline acts as a put on the last column that stores nothing.
				if (r.ch == CHAR_NEWLINE) cur_col = COLS - 1;
				else screen_cells[cur_row * COLS + cur_col] = {attr, r.ch};
				cur_col++;
				if (cur_col == COLS) begin
					cur_col = 0;
					cur_row++;
					// Past the bottom row the screen moves up and the last row is blanked.
					if (cur_row == ROWS) begin
						for (int i = 0; i < NCELLS - COLS; i++)
							screen_cells[i] = screen_cells[i + COLS];
						for (int i = NCELLS - COLS; i < NCELLS; i++)
							screen_cells[i] = BLANK_CELL;
						cur_row = ROWS - 1;
						res.did_scroll = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				blank_screen();
			end
			CMD_READ: begin
				// A cell outside the screen reads as zero.
				if (r.row < ROWS && r.col < COLS)
					res.cell_value = screen_cells[r.row * COLS + r.col];
			end
			default: begin
			end
		endcase
		res.cursor_row = ROW_OUT_W'(cur_row);
		res.cursor_col = COL_OUT_W'(cur_col);
		return res;
	endfunction

	function automatic console_req_t mk_req(logic [1:0] op, logic [7:0] ch, logic own,
			logic [7:0] color, logic [4:0] row, logic [6:0] col);
		console_req_t r;
		r.op        = op;
		r.ch        = ch;
		r.own_color = own;
		r.color     = color;
		r.row       = row;
		r.col       = col;
		return r;
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) return $urandom_range(1, 2);
		if (sel < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Random request: many puts with frequent newlines so the cursor reaches the
	// bottom and scrolls, reads half aimed at the cursor row, unused codes, rare clears.
	function automatic console_req_t random_req();
		console_req_t r;
		int           sel;
		r.ch        = 8'($urandom);
		r.own_color = 1'($urandom);
		r.color     = 8'($urandom);
		r.row       = 5'($urandom);
		r.col       = 7'($urandom);
		sel = $urandom_range(0, 999);
		if (sel < 550) begin
			r.op = CMD_PUT;
			if ($urandom_range(0, 3) == 0) r.ch = CHAR_NEWLINE;
		end else if (sel < 553) begin
			r.op = CMD_CLEAR;
		end else if (sel < 573) begin
			r.op = CMD_UNUSED;
		end else begin
			r.op = CMD_READ;
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				r.row = 5'(cur_row);
				r.col = 7'($urandom_range(0, COLS - 1));
			end else if (sel < 8) begin
				r.row = 5'($urandom_range(0, ROWS - 1));
				r.col = 7'($urandom_range(0, COLS - 1));
			end
		end
		return r;
	endfunction

	// Offers one request after an optional gap and waits until it is taken.
	// Valid stays high on return so that a following request can go back to back.
	task automatic send_request(input console_req_t r);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd            <= r.op;
		char_code      <= r.ch;
		use_item_color <= r.own_color;
		item_color     <= r.color;
		read_row       <= r.row;
		read_col       <= r.col;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(console_apply(r));
	endtask

	// Stops offering and waits until every outstanding result has come back.
	task automatic drain_requests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_default_color(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		attr_default = value;
	endtask

	// Compares one result with the oldest outstanding prediction.
	task automatic check_result();
		tcw_result_t want;
		if (pending_results.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: result with no request outstanding, cell %h",
					$time, cell_value);
		end else begin
			want = pending_results.pop_front();
			if (cell_value !== want.cell_value || cursor_row_now !== want.cursor_row
					|| cursor_col_now !== want.cursor_col
					|| did_scroll !== want.did_scroll) begin
				error_count++;
				if (error_count <= 10) begin
					$write("%0t: expected cell %h row %0d col %0d scroll %b,", $time,
						want.cell_value, want.cursor_row, want.cursor_col,
						want.did_scroll);
					$display(" got cell %h row %0d col %0d scroll %b", cell_value,
						cursor_row_now, cursor_col_now, did_scroll);
				end
			end
		end
	endtask

	// Result side: checks each taken result and drives random and long stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) check_result();
			if (hold_request) begin
				hold_left    = PRESSURE_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left = idle_length() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Field extremes, every command, reads off the screen, newline and clear.
	task automatic test_directed();
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS - 1), 7'(COLS - 1)));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'(ROWS), 7'd0));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'(COLS)));
		send_request(mk_req(CMD_READ, 8'hFF, 1'b1, 8'hFF, 5'd31, 7'd127));
		send_request(mk_req(CMD_PUT, 8'h41, 1'b0, 8'h12, 5'd0, 7'd0));
		send_request(mk_req(CMD_PUT, 8'h00, 1'b1, 8'hFF, 5'd31, 7'd127));
		send_request(mk_req(CMD_PUT, 8'hFF, 1'b1, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(CMD_PUT, CHAR_NEWLINE, 1'b1, 8'h5A, 5'd0, 7'd0));
		send_request(mk_req(CMD_PUT, 8'h7E, 1'b1, 8'hA5, 5'd0, 7'd0));
		send_request(mk_req(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF, 5'd31, 7'd127));
		for (int c = 0; c < 4; c++)
			send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'(c)));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd1, 7'd0));
		send_request(mk_req(CMD_CLEAR, 8'hFF, 1'b1, 8'hFF, 5'd31, 7'd127));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd1, 7'd0));
		send_request(mk_req(CMD_PUT, 8'h20, 1'b0, 8'h00, 5'd0, 7'd0));
		send_request(mk_req(CMD_READ, 8'h00, 1'b0, 8'h00, 5'd0, 7'd0));
	endtask

	// The result side holds off for a long stretch while requests keep coming
	// back to back, so the block fills up and pushes back on its input.
	task automatic test_pressure();
		console_req_t r;
		tx_gaps_on   = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++) begin
			r = random_req();
			if (r.op == CMD_CLEAR) r.op = CMD_PUT;
			send_request(r);
		end
		tx_gaps_on = 1'b1;
		drain_requests();
	endtask

	// Random traffic; idling on each side is switched off now and then.
	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				tx_gaps_on   = ($urandom_range(0, 4) != 0);
				rx_stalls_on = ($urandom_range(0, 4) != 0);
			end
			send_request(random_req());
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Ends the run if it goes on far longer than any correct run could.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_text_console_char_writer_top: FAIL");
		$finish;
	end

	initial begin
		logic [7:0] phase_colors [4];
		phase_colors = '{8'h00, 8'h80, 8'h00, 8'h7F};
		phase_colors[2] = 8'($urandom);
		blank_screen();
		attr_default = DEFAULT_COLOR_RST;

		// Reset, then wait out the clearing sweep before touching the register.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		write_default_color(8'hFF);

		test_directed();
		test_pressure();
		foreach (phase_colors[p]) begin
			drain_requests();
			write_default_color(phase_colors[p]);
			test_random(360);
		end

		// Let any stray result show up before the verdict.
		drain_requests();
		repeat (SWEEP_CYCLES) @(posedge clk);
		error_count += pending_results.size();
		if (error_count == 0)
			$display("tb_text_console_char_writer_top: PASS");
		else
			$display("tb_text_console_char_writer_top: FAIL");
		$finish;
	end

endmodule
